>>> hdl/rvq_pkg.sv
// Shared constants, types and helpers for the rotation vector to quaternion pipeline.
package rvq_pkg;

    localparam int ANG_W  = 36;   // Q30 angles and CORDIC vectors, signed
    localparam int DVD_W  = 62;   // |sin| in Q30, shifted up by 30
    localparam int DIV_W  = 36;   // divisor (theta, Q30), positive
    localparam int G_W    = 31;   // gain magnitude, below 2^30 in practice
    localparam int Q_W    = 16;   // Q1.14 result width
    localparam int RND_W  = 64;   // widest magnitude fed to the rounding helper

    typedef logic signed [ANG_W-1:0] t_ang;

    localparam t_ang PI_Q30      = 36'sd3373259426;
    localparam t_ang PI_HALF_Q30 = 36'sd1686629713;
    localparam t_ang SMALL_Q30   = 36'sd107374;
    localparam t_ang GAIN_Q30    = 36'sd652032874;
    localparam logic [Q_W-1:0] Q14_ONE = 16'd16384;

    function automatic t_ang atan_q30(input int idx);
        t_ang a;
        case (idx)
            0:  a = 36'sd843314856;
            1:  a = 36'sd497837829;
            2:  a = 36'sd263043836;
            3:  a = 36'sd133525158;
            4:  a = 36'sd67021686;
            5:  a = 36'sd33543515;
            6:  a = 36'sd16775850;
            7:  a = 36'sd8388437;
            8:  a = 36'sd4194282;
            9:  a = 36'sd2097149;
            10: a = 36'sd1048575;
            11: a = 36'sd524287;
            12: a = 36'sd262143;
            13: a = 36'sd131071;
            14: a = 36'sd65535;
            15: a = 36'sd32767;
            16: a = 36'sd16383;
            17: a = 36'sd8191;
            18: a = 36'sd4095;
            19: a = 36'sd2047;
            20: a = 36'sd1023;
            21: a = 36'sd511;
            22: a = 36'sd255;
            23: a = 36'sd127;
            default: a = '0;
        endcase
        return a;
    endfunction

    // Round half away from zero by 2^-sh, saturate magnitude to one, apply sign.
    function automatic logic [Q_W-1:0] q14_round(input logic neg,
                                                 input logic [RND_W-1:0] mag,
                                                 input int sh);
        logic [RND_W-1:0] q;
        logic [Q_W-1:0]   m;
        q = (mag + (RND_W'(1) << (sh - 1))) >> sh;
        m = (q > RND_W'(Q14_ONE)) ? Q14_ONE : q[Q_W-1:0];
        return neg ? Q_W'(-m) : m;
    endfunction

endpackage

>>> hdl/rvq_lane_sq.sv
// Squaring lane: magnitude of one rotation component, squared and registered.
module rvq_lane_sq #(
    parameter int W = 16
) (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic [W-1:0]       i_r,
    output logic [2*W-1:0]     o_sq
);
    logic [W-1:0]   mag;
    logic [2*W-1:0] r_sq;

    assign mag = i_r[W-1] ? W'(~i_r + W'(1)) : i_r;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sq <= mag * mag;
        end
    end

    assign o_sq = r_sq;
endmodule

>>> hdl/rvq_sqrt.sv
// Pipelined integer square root, one root bit per stage.
module rvq_sqrt #(
    parameter int NW    = 17,
    parameter int TAG_W = 48
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_vld,
    input  logic [2*NW-1:0]   i_n,
    input  logic [TAG_W-1:0]  i_tag,
    output logic              o_vld,
    output logic [NW-1:0]     o_root,
    output logic [TAG_W-1:0]  o_tag
);
    logic [2*NW-1:0]  s_n    [0:NW-1];
    logic [NW+1:0]    s_rem  [0:NW-1];
    logic [NW-1:0]    s_root [0:NW-1];
    logic [TAG_W-1:0] s_tag  [0:NW-1];
    logic             s_vld  [0:NW-1];

    logic [2*NW-1:0]  r_n    [1:NW];
    logic [NW+1:0]    r_rem  [1:NW];
    logic [NW-1:0]    r_root [1:NW];
    logic [TAG_W-1:0] r_tag  [1:NW];
    logic             r_vld  [1:NW];

    genvar k;
    generate
        for (k = 0; k < NW; k++) begin : g_stage
            logic [NW+1:0] rem_sh;
            logic [NW+1:0] trial;
            logic          ge;

            if (k == 0) begin : g_head
                assign s_n[k]    = i_n;
                assign s_rem[k]  = '0;
                assign s_root[k] = '0;
                assign s_tag[k]  = i_tag;
                assign s_vld[k]  = i_vld;
            end else begin : g_body
                assign s_n[k]    = r_n[k];
                assign s_rem[k]  = r_rem[k];
                assign s_root[k] = r_root[k];
                assign s_tag[k]  = r_tag[k];
                assign s_vld[k]  = r_vld[k];
            end

            // remainder stays below 2^NW before the final shift-in
            assign rem_sh = {s_rem[k][NW-1:0], s_n[k][2*NW-1 -: 2]};
            assign trial  = {s_root[k], 2'b01};
            assign ge     = (rem_sh >= trial);

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_vld[k+1] <= 1'b0;
                end else if (i_en) begin
                    r_vld[k+1] <= s_vld[k];
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_n[k+1]    <= s_n[k] << 2;
                    r_rem[k+1]  <= ge ? (rem_sh - trial) : rem_sh;
                    r_root[k+1] <= {s_root[k][NW-2:0], ge};
                    r_tag[k+1]  <= s_tag[k];
                end
            end
        end
    endgenerate

    assign o_vld  = r_vld[NW];
    assign o_root = r_root[NW];
    assign o_tag  = r_tag[NW];
endmodule

>>> hdl/rvq_cordic.sv
// Pipelined rotation-mode CORDIC in Q30, one micro-rotation per stage.
module rvq_cordic #(
    parameter int STEPS = 16,
    parameter int TAG_W = 48
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_vld,
    input  rvq_pkg::t_ang       i_ang,
    input  logic [TAG_W-1:0]    i_tag,
    output logic                o_vld,
    output rvq_pkg::t_ang       o_cos,
    output rvq_pkg::t_ang       o_sin,
    output logic [TAG_W-1:0]    o_tag
);
    import rvq_pkg::*;

    t_ang             s_x   [0:STEPS-1];
    t_ang             s_y   [0:STEPS-1];
    t_ang             s_z   [0:STEPS-1];
    logic [TAG_W-1:0] s_tag [0:STEPS-1];
    logic             s_vld [0:STEPS-1];

    t_ang             r_x   [1:STEPS];
    t_ang             r_y   [1:STEPS];
    t_ang             r_z   [1:STEPS];
    logic [TAG_W-1:0] r_tag [1:STEPS];
    logic             r_vld [1:STEPS];

    genvar k;
    generate
        for (k = 0; k < STEPS; k++) begin : g_stage
            t_ang dx;
            t_ang dy;

            if (k == 0) begin : g_head
                assign s_x[k]   = GAIN_Q30;
                assign s_y[k]   = '0;
                assign s_z[k]   = i_ang;
                assign s_tag[k] = i_tag;
                assign s_vld[k] = i_vld;
            end else begin : g_body
                assign s_x[k]   = r_x[k];
                assign s_y[k]   = r_y[k];
                assign s_z[k]   = r_z[k];
                assign s_tag[k] = r_tag[k];
                assign s_vld[k] = r_vld[k];
            end

            assign dx = s_y[k] >>> k;
            assign dy = s_x[k] >>> k;

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_vld[k+1] <= 1'b0;
                end else if (i_en) begin
                    r_vld[k+1] <= s_vld[k];
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    if (!s_z[k][ANG_W-1]) begin
                        r_x[k+1] <= s_x[k] - dx;
                        r_y[k+1] <= s_y[k] + dy;
                        r_z[k+1] <= s_z[k] - atan_q30(k);
                    end else begin
                        r_x[k+1] <= s_x[k] + dx;
                        r_y[k+1] <= s_y[k] - dy;
                        r_z[k+1] <= s_z[k] + atan_q30(k);
                    end
                    r_tag[k+1] <= s_tag[k];
                end
            end
        end
    endgenerate

    assign o_vld = r_vld[STEPS];
    assign o_cos = r_x[STEPS];
    assign o_sin = r_y[STEPS];
    assign o_tag = r_tag[STEPS];
endmodule

>>> hdl/rvq_div.sv
// Pipelined restoring divider, one quotient bit per stage.
module rvq_div #(
    parameter int TAG_W = 48
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_vld,
    input  logic [rvq_pkg::DVD_W-1:0]   i_dvd,
    input  logic [rvq_pkg::DIV_W-1:0]   i_div,
    input  logic [TAG_W-1:0]            i_tag,
    output logic                        o_vld,
    output logic [rvq_pkg::G_W-1:0]     o_quo,
    output logic [TAG_W-1:0]            o_tag
);
    import rvq_pkg::*;

    logic [DVD_W-1:0] s_q   [0:DVD_W-1];
    logic [DIV_W-1:0] s_rem [0:DVD_W-1];
    logic [DIV_W-1:0] s_d   [0:DVD_W-1];
    logic [TAG_W-1:0] s_tag [0:DVD_W-1];
    logic             s_vld [0:DVD_W-1];

    // dividend bits shift out of r_q while quotient bits shift in
    logic [DVD_W-1:0] r_q   [1:DVD_W];
    logic [DIV_W-1:0] r_rem [1:DVD_W];
    logic [DIV_W-1:0] r_d   [1:DVD_W];
    logic [TAG_W-1:0] r_tag [1:DVD_W];
    logic             r_vld [1:DVD_W];

    genvar k;
    generate
        for (k = 0; k < DVD_W; k++) begin : g_stage
            logic [DIV_W:0] rem_sh;
            logic           ge;

            if (k == 0) begin : g_head
                assign s_q[k]   = i_dvd;
                assign s_rem[k] = '0;
                assign s_d[k]   = i_div;
                assign s_tag[k] = i_tag;
                assign s_vld[k] = i_vld;
            end else begin : g_body
                assign s_q[k]   = r_q[k];
                assign s_rem[k] = r_rem[k];
                assign s_d[k]   = r_d[k];
                assign s_tag[k] = r_tag[k];
                assign s_vld[k] = r_vld[k];
            end

            assign rem_sh = {s_rem[k], s_q[k][DVD_W-1]};
            assign ge     = (rem_sh >= {1'b0, s_d[k]});

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_vld[k+1] <= 1'b0;
                end else if (i_en) begin
                    r_vld[k+1] <= s_vld[k];
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k+1] <= ge ? DIV_W'(rem_sh - {1'b0, s_d[k]}) : rem_sh[DIV_W-1:0];
                    r_q[k+1]   <= {s_q[k][DVD_W-2:0], ge};
                    r_d[k+1]   <= s_d[k];
                    r_tag[k+1] <= s_tag[k];
                end
            end
        end
    endgenerate

    assign o_vld = r_vld[DVD_W];
    assign o_quo = r_q[DVD_W][G_W-1:0];
    assign o_tag = r_tag[DVD_W];
endmodule

>>> hdl/rvq_lane_out.sv
// Output lane: component times gain, then rounding to Q1.14 in the output register.
module rvq_lane_out #(
    parameter int W    = 16,
    parameter int FRAC = 13
) (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  logic [W-1:0]               i_r,
    input  logic                       i_gneg,
    input  logic [rvq_pkg::G_W-1:0]    i_gm,
    output logic [rvq_pkg::Q_W-1:0]    o_q
);
    import rvq_pkg::*;

    logic [W-1:0]     mag;
    logic [W+G_W-1:0] r_p;
    logic             r_neg;
    logic [Q_W-1:0]   r_q;

    assign mag = i_r[W-1] ? W'(~i_r + W'(1)) : i_r;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p   <= mag * i_gm;
            r_neg <= i_r[W-1] ^ i_gneg;
            r_q   <= q14_round(r_neg, RND_W'(r_p), FRAC + 16);
        end
    end

    assign o_q = r_q;
endmodule

>>> hdl/rotation_vector_to_quaternion_top.sv
// Top level: rotation vector to unit quaternion, fully pipelined.
//
//  channel | dir | tdata fields (low bit up)                  | handshake
//  s_axis  | in  | rot_x, rot_y, rot_z (IN_WIDTH each, signed) | tvalid/tready
//  m_axis  | out | quat_w, quat_x, quat_y, quat_z (16 each)    | tvalid/tready
//
// One item per cycle while the output is not stalled. The pipeline depth is set by the
// root, CORDIC and divider pipelines (one bit or step a stage).
// Synchronous active-low reset clears all valid bits; data registers are not reset.
// A stalled output freezes the whole pipeline; input is ready while the output
// register is empty or being taken.
module rotation_vector_to_quaternion_top #(
    parameter int CORDIC_STEPS = 16,
    parameter int IN_WIDTH     = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_s_axis_tvalid,
    output logic                                   o_s_axis_tready,
    // rot_x, rot_y, rot_z
    input  logic [((3*IN_WIDTH+7)/8)*8-1:0]        i_s_axis_tdata,
    output logic                                   o_m_axis_tvalid,
    input  logic                                   i_m_axis_tready,
    // quat_w, quat_x, quat_y, quat_z
    output logic [63:0]                            o_m_axis_tdata
);
    import rvq_pkg::*;

    localparam int W     = IN_WIDTH;
    localparam int FRAC  = IN_WIDTH - 3;
    localparam int NW    = IN_WIDTH + 1;
    localparam int RV_W  = 3 * IN_WIDTH;
    localparam int C_TAG = 1 + DIV_W + RV_W;
    localparam int D_TAG = ANG_W + 1 + RV_W;

    logic en;
    assign en = !o_m_axis_tvalid || i_m_axis_tready;
    assign o_s_axis_tready = en;

    logic [RV_W-1:0] in_rv;
    assign in_rv = i_s_axis_tdata[RV_W-1:0];

    // squaring lanes
    logic [2*W-1:0] sq [0:2];
    logic           r_a_vld;
    logic [RV_W-1:0] r_a_rv;

    genvar li;
    generate
        for (li = 0; li < 3; li++) begin : g_sq
            rvq_lane_sq #(.W(W)) u_sq (
                .i_clk (i_clk),
                .i_en  (en),
                .i_r   (in_rv[li*W +: W]),
                .o_sq  (sq[li])
            );
        end
    endgenerate

    // sum of squares
    logic               r_b_vld;
    logic [2*NW-1:0]    r_b_sum;
    logic [RV_W-1:0]    r_b_rv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
        end else if (en) begin
            r_a_vld <= i_s_axis_tvalid;
            r_b_vld <= r_a_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_rv  <= in_rv;
            r_b_sum <= (2*NW)'(sq[0]) + (2*NW)'(sq[1]) + (2*NW)'(sq[2]);
            r_b_rv  <= r_a_rv;
        end
    end

    logic            sq_vld;
    logic [NW-1:0]   root;
    logic [RV_W-1:0] sq_rv;

    rvq_sqrt #(.NW(NW), .TAG_W(RV_W)) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (r_b_vld),
        .i_n     (r_b_sum),
        .i_tag   (r_b_rv),
        .o_vld   (sq_vld),
        .o_root  (root),
        .o_tag   (sq_rv)
    );

    // angle fold and divisor
    logic [ANG_W-1:0] theta30;
    t_ang             half;
    logic             fold;
    assign theta30 = ANG_W'(root) << (30 - FRAC);
    assign half    = t_ang'(theta30 >> 1);
    assign fold    = (half > PI_HALF_Q30);

    logic            r_c_vld;
    t_ang            r_c_ang;
    logic            r_c_neg;
    logic [DIV_W-1:0] r_c_div;
    logic [RV_W-1:0] r_c_rv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_vld <= 1'b0;
        end else if (en) begin
            r_c_vld <= sq_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c_ang <= fold ? (PI_Q30 - half) : half;
            r_c_neg <= fold;
            r_c_div <= (t_ang'(theta30) < SMALL_Q30) ? DIV_W'(theta30 + SMALL_Q30)
                                                     : DIV_W'(theta30);
            r_c_rv  <= sq_rv;
        end
    end

    logic             co_vld;
    t_ang             co_cos;
    t_ang             co_sin;
    logic [C_TAG-1:0] co_tag;

    rvq_cordic #(.STEPS(CORDIC_STEPS), .TAG_W(C_TAG)) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (r_c_vld),
        .i_ang   (r_c_ang),
        .i_tag   ({r_c_neg, r_c_div, r_c_rv}),
        .o_vld   (co_vld),
        .o_cos   (co_cos),
        .o_sin   (co_sin),
        .o_tag   (co_tag)
    );

    // sign split ahead of the divider
    logic             r_d_vld;
    t_ang             r_d_cos;
    logic             r_d_sneg;
    logic [31:0]      r_d_smag;
    logic [DIV_W-1:0] r_d_div;
    logic [RV_W-1:0]  r_d_rv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_vld <= 1'b0;
        end else if (en) begin
            r_d_vld <= co_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d_cos  <= co_tag[C_TAG-1] ? -co_cos : co_cos;
            r_d_sneg <= co_sin[ANG_W-1];
            r_d_smag <= co_sin[ANG_W-1] ? 32'(-co_sin) : 32'(co_sin);
            r_d_div  <= co_tag[RV_W +: DIV_W];
            r_d_rv   <= co_tag[RV_W-1:0];
        end
    end

    logic             dv_vld;
    logic [G_W-1:0]   gm;
    logic [D_TAG-1:0] dv_tag;

    rvq_div #(.TAG_W(D_TAG)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (r_d_vld),
        .i_dvd   ({r_d_smag, 30'd0}),
        .i_div   (r_d_div),
        .i_tag   ({r_d_cos, r_d_sneg, r_d_rv}),
        .o_vld   (dv_vld),
        .o_quo   (gm),
        .o_tag   (dv_tag)
    );

    t_ang            dv_cos;
    logic            dv_gneg;
    logic [RV_W-1:0] dv_rv;
    assign dv_cos  = dv_tag[D_TAG-1 -: ANG_W];
    assign dv_gneg = dv_tag[RV_W];
    assign dv_rv   = dv_tag[RV_W-1:0];

    // merge: scalar part beside the three vector lanes
    logic [Q_W-1:0] qv [0:2];

    generate
        for (li = 0; li < 3; li++) begin : g_out
            rvq_lane_out #(.W(W), .FRAC(FRAC)) u_out (
                .i_clk  (i_clk),
                .i_en   (en),
                .i_r    (dv_rv[li*W +: W]),
                .i_gneg (dv_gneg),
                .i_gm   (gm),
                .o_q    (qv[li])
            );
        end
    endgenerate

    logic             r_e_vld;
    logic             r_o_vld;
    logic             r_e_cneg;
    logic [ANG_W-1:0] r_e_cmag;
    logic [Q_W-1:0]   r_o_w;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_vld <= 1'b0;
            r_o_vld <= 1'b0;
        end else if (en) begin
            r_e_vld <= dv_vld;
            r_o_vld <= r_e_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_e_cneg <= dv_cos[ANG_W-1];
            r_e_cmag <= dv_cos[ANG_W-1] ? ANG_W'(-dv_cos) : ANG_W'(dv_cos);
            r_o_w    <= q14_round(r_e_cneg, RND_W'(r_e_cmag), 16);
        end
    end

    assign o_m_axis_tvalid = r_o_vld;
    assign o_m_axis_tdata  = {qv[2], qv[1], qv[0], r_o_w};

    // input side is never blocked while the output register is empty
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_axis_tvalid |-> o_s_axis_tready)
        else $error("input stalled with empty output register");

    a_w_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> ($signed(r_o_w) <= 16384 && $signed(r_o_w) >= -16384))
        else $error("quat_w out of range");

    a_xyz_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> ($signed(qv[0]) <= 16384 && $signed(qv[0]) >= -16384 &&
                             $signed(qv[1]) <= 16384 && $signed(qv[1]) >= -16384 &&
                             $signed(qv[2]) <= 16384 && $signed(qv[2]) >= -16384))
        else $error("vector part out of range");

    // a stall must not drop the item held at the output
    a_stall_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=> o_m_axis_tvalid)
        else $error("output item lost under stall");
endmodule
